>>> rtl/clipped_line_rasterizer_core_assert.svh
// Assertion macros for the clipped line rasterizer.
// Included by the top level; depends on nothing else.
`ifndef CLIPPED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("clr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("clr assertion failed");

`endif

>>> rtl/clr_pkg.sv
// Package for the clipped line rasterizer: coordinate constants, codes and
// the window test. Depends on nothing.
package clr_pkg;

    localparam int COORD_BITS = 16;
    localparam int COORD_EFF  = (COORD_BITS < 16) ? COORD_BITS : 16;

    // Coordinate range, held 17 bits wide so a step past a 16-bit edge is seen
    localparam logic signed [16:0] COORD_MIN = 17'(-(2 ** (COORD_EFF - 1)));
    localparam logic signed [16:0] COORD_MAX = 17'((2 ** (COORD_EFF - 1)) - 1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_MIN_X = 3'd0,
        CFG_MAX_X = 3'd1,
        CFG_MIN_Y = 3'd2,
        CFG_MAX_Y = 3'd3,
        CFG_STOP  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
    } t_window;

    function automatic logic f_inside(input logic signed [16:0] x,
                                      input logic signed [16:0] y,
                                      input t_window w);
        logic in_range;
        logic in_win;
        in_range = (x >= COORD_MIN) && (x <= COORD_MAX) &&
                   (y >= COORD_MIN) && (y <= COORD_MAX);
        in_win   = (x >= 17'(w.min_x)) && (x <= 17'(w.max_x)) &&
                   (y >= 17'(w.min_y)) && (y <= 17'(w.max_y));
        return in_range && in_win;
    endfunction

endpackage

>>> rtl/clipped_line_rasterizer_core.sv
// Clipped line rasterizer: Bresenham point generator with a stop window.
// An accepted transaction is held in the stage-1 register, then its result in the result register on m_axis.
// Throughput: one transaction per cycle while m_axis does not stall, set by the single add-compare step.
// Reset: synchronous, active low; clears the pipeline, the active line and
// loads the full window with stop-at-end set. Uses clr_pkg and the assert header.
`include "clipped_line_rasterizer_core_assert.svh"

module clipped_line_rasterizer_core
    import clr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_axis_tuser,   // operation
    // point stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // point_x, point_y
    output logic        m_axis_tlast,   // last_point
    output logic [1:0]  m_axis_tuser    // point_valid, left_window
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_window r_win;
    logic    r_stop_at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.min_x   <= 16'sh8000;
            r_win.max_x   <= 16'sh7FFF;
            r_win.min_y   <= 16'sh8000;
            r_win.max_y   <= 16'sh7FFF;
            r_stop_at_end <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X: r_win.min_x   <= i_cfg_data;
                CFG_MAX_X: r_win.max_x   <= i_cfg_data;
                CFG_MIN_Y: r_win.min_y   <= i_cfg_data;
                CFG_MAX_Y: r_win.max_y   <= i_cfg_data;
                CFG_STOP:  r_stop_at_end <= i_cfg_data[0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the whole pipe advances when the result register is
    // empty or being emptied this cycle.
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || advance;

    // ---------------------------------------------------------------
    // Stage 1: capture the transaction and set up the line increments.
    // These depend only on the endpoints, so they run ahead of the state.
    // ---------------------------------------------------------------
    logic signed [15:0] in_x1, in_y1, in_x2, in_y2;
    logic signed [16:0] in_dx, in_dy;
    logic        [15:0] in_dxa;
    logic signed [16:0] in_dyn;

    assign in_x1 = s_axis_tdata[15:0];
    assign in_y1 = s_axis_tdata[31:16];
    assign in_x2 = s_axis_tdata[47:32];
    assign in_y2 = s_axis_tdata[63:48];

    always_comb begin
        in_dx  = 17'(in_x2) - 17'(in_x1);
        in_dy  = 17'(in_y2) - 17'(in_y1);
        in_dxa = in_dx[16] ? 16'(-in_dx) : in_dx[15:0];
        in_dyn = in_dy[16] ? in_dy : -in_dy;
    end

    t_op                r_s1_op;
    logic signed [15:0] r_s1_x1, r_s1_y1, r_s1_x2, r_s1_y2;
    logic        [15:0] r_s1_dxa;
    logic signed [16:0] r_s1_dyn;
    logic               r_s1_sxn, r_s1_syn;
    logic signed [17:0] r_s1_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_op  <= t_op'(s_axis_tuser);
            r_s1_x1  <= in_x1;
            r_s1_y1  <= in_y1;
            r_s1_x2  <= in_x2;
            r_s1_y2  <= in_y2;
            r_s1_dxa <= in_dxa;
            r_s1_dyn <= in_dyn;
            r_s1_sxn <= !(in_x1 < in_x2);
            r_s1_syn <= !(in_y1 < in_y2);
            r_s1_err <= $signed({2'b00, in_dxa}) + 18'(in_dyn);
        end
    end

    // ---------------------------------------------------------------
    // Line state
    // ---------------------------------------------------------------
    logic signed [15:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic        [15:0] r_dxa;
    logic signed [16:0] r_dyn;
    logic               r_sxn, r_syn;
    logic signed [17:0] r_err;
    logic               r_active;

    // Stage 2: one Bresenham step on either the fresh line or the held one
    logic               is_start;
    logic signed [15:0] cx, cy, tx, ty;
    logic        [15:0] dxa;
    logic signed [16:0] dyn;
    logic               sxn, syn;
    logic signed [17:0] err;
    logic signed [18:0] e2;
    logic               step_x, step_y;
    logic signed [16:0] nx, ny;
    logic signed [17:0] ne;
    logic               cur_in, next_in, at_end;

    always_comb begin
        is_start = (r_s1_op == OP_START);
        cx  = is_start ? r_s1_x1  : r_cur_x;
        cy  = is_start ? r_s1_y1  : r_cur_y;
        tx  = is_start ? r_s1_x2  : r_tgt_x;
        ty  = is_start ? r_s1_y2  : r_tgt_y;
        dxa = is_start ? r_s1_dxa : r_dxa;
        dyn = is_start ? r_s1_dyn : r_dyn;
        sxn = is_start ? r_s1_sxn : r_sxn;
        syn = is_start ? r_s1_syn : r_syn;
        err = is_start ? r_s1_err : r_err;

        e2     = {err, 1'b0};
        step_x = (e2 >= 19'(dyn));
        step_y = (e2 <= $signed({3'b000, dxa}));
        ne     = err + (step_x ? 18'(dyn) : 18'sd0)
                     + (step_y ? $signed({2'b00, dxa}) : 18'sd0);
        nx     = 17'(cx) + (step_x ? (sxn ? -17'sd1 : 17'sd1) : 17'sd0);
        ny     = 17'(cy) + (step_y ? (syn ? -17'sd1 : 17'sd1) : 17'sd0);

        cur_in  = f_inside(17'(cx), 17'(cy), r_win);
        next_in = f_inside(nx, ny, r_win);
        at_end  = r_stop_at_end && (cx == tx) && (cy == ty);
    end

    // Result and state decision
    logic               n_active;
    logic               n_advance_pt;
    logic signed [15:0] n_out_x, n_out_y;
    logic               n_out_pv, n_out_last, n_out_left;

    always_comb begin
        n_active     = r_active;
        n_advance_pt = 1'b0;
        n_out_x      = '0;
        n_out_y      = '0;
        n_out_pv     = 1'b0;
        n_out_last   = 1'b0;
        n_out_left   = 1'b0;
        if (!is_start && !r_active) begin
            // no line in progress: one empty result, state untouched
        end else if (!cur_in) begin
            n_active   = 1'b0;
            n_out_last = 1'b1;
            n_out_left = 1'b1;
        end else begin
            n_out_x  = cx;
            n_out_y  = cy;
            n_out_pv = 1'b1;
            if (at_end) begin
                n_active   = 1'b0;
                n_out_last = 1'b1;
            end else if (!next_in) begin
                n_active   = 1'b0;
                n_out_last = 1'b1;
                n_out_left = 1'b1;
            end else begin
                n_active     = 1'b1;
                n_advance_pt = 1'b1;
            end
        end
    end

    logic fire2;
    assign fire2 = r_s1_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (fire2) begin
            r_active <= n_active;
        end
    end

    // Load the line on start; move the point only when a step was taken
    always_ff @(posedge i_clk) begin
        if (fire2) begin
            if (is_start) begin
                r_tgt_x <= r_s1_x2;
                r_tgt_y <= r_s1_y2;
                r_dxa   <= r_s1_dxa;
                r_dyn   <= r_s1_dyn;
                r_sxn   <= r_s1_sxn;
                r_syn   <= r_s1_syn;
            end
            if (n_advance_pt) begin
                r_cur_x <= nx[15:0];
                r_cur_y <= ny[15:0];
                r_err   <= ne;
            end else if (is_start) begin
                r_cur_x <= r_s1_x1;
                r_cur_y <= r_s1_y1;
                r_err   <= r_s1_err;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register: holds while the downstream stalls
    // ---------------------------------------------------------------
    logic signed [15:0] r_out_x, r_out_y;
    logic               r_out_pv, r_out_last, r_out_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire2) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_pv   <= n_out_pv;
            r_out_last <= n_out_last;
            r_out_left <= n_out_left;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_left, r_out_pv};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // A line that left the window always ends there
    `CLR_ASSERT_NOW(a_left_is_last, i_clk, i_rst_n, r_out_valid && r_out_left, r_out_last)
    // A delivered point that does not end the line leaves a line in progress
    `CLR_ASSERT_NOW(a_open_line_active, i_clk, i_rst_n, r_out_valid && r_out_pv && !r_out_last, r_active)
    // An empty result carries a zero point
    `CLR_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, r_out_valid && !r_out_pv, r_out_x == 16'sd0 && r_out_y == 16'sd0)
    // A stalled stage-one transaction is not lost
    `CLR_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !advance, r_s1_valid)

endmodule
